@@ sv/dpc_pkg.sv @@
// Shared types, widths and register codes of the dark pixel centroid block.
package dpc_pkg;

    // Field and accumulator widths
    localparam int PIX_W       = 8;
    localparam int COORD_W     = 12;
    localparam int COUNT_W     = 25;
    localparam int SUM_W       = 36;
    localparam int CFG_SIZE_W  = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;

    // Default frame bounds
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Register reset values
    localparam logic [PIX_W-1:0]      THRESHOLD_RESET = 8'd255;
    localparam logic [CFG_SIZE_W-1:0] WIDTH_RESET     = 13'd640;
    localparam logic [CFG_SIZE_W-1:0] HEIGHT_RESET    = 13'd480;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DARK_THRESHOLD = 2'd0,
        REG_FRAME_WIDTH    = 2'd1,
        REG_FRAME_HEIGHT   = 2'd2
    } dpc_reg_index_t;

    // Frame sequencer states
    typedef enum logic [1:0] {
        ST_ACCUM = 2'd0,
        ST_DIV_X = 2'd1,
        ST_DIV_Y = 2'd2,
        ST_FLUSH = 2'd3
    } dpc_state_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } dpc_div_stat_t;

endpackage

@@ sv/dpc_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, shared for both axes.
module dpc_div
    import dpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SUM_W-1:0]   dividend,
    input  logic [COUNT_W-1:0] divisor,
    output logic [SUM_W-1:0]   quotient,
    output dpc_div_stat_t      stat
);

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [COUNT_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]    quo_reg, quo_next;
    logic [COUNT_W-1:0]  divisor_reg, divisor_next;
    logic [COUNT_W:0]    rem_shift;
    logic [COUNT_W:0]    rem_diff;
    logic                take;

    // Trial subtract of one shifted-in dividend bit
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[SUM_W-1]};
        rem_diff  = rem_shift - {1'b0, divisor_reg};
        take      = (rem_shift >= {1'b0, divisor_reg});
    end

    // Load on start, otherwise advance one bit while busy
    always_comb
    begin
        busy_next    = busy_reg;
        step_next    = step_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        done_next    = busy_reg && (step_reg == LAST_STEP);
        if (start)
        begin
            busy_next    = 1'b1;
            step_next    = '0;
            rem_next     = '0;
            quo_next     = dividend;
            divisor_next = divisor;
            done_next    = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next = take ? rem_diff[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], take};
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ sv/dark_pixel_centroid.sv @@
// Top level of the dark pixel centroid block: accumulation, sequencer and output register.
// Pixels of a frame enter in raster order at one per clock unless in_stall is high;
// each pixel below dark_threshold adds its column and row to 36-bit sums and bumps
// a 25-bit count. On the last pixel of a frame with at least one dark pixel, one
// shared radix-2 divider forms the mean column and then the mean row while the
// input stalls; a frame without dark pixels stalls only in the flush state. Either
// stall lasts longer while the previous result still waits in the output register.
// The result sits in an output register, and pixels of the next frame are
// taken while it waits. A frame size of 0 acts as 1 and one above
// MAX_WIDTH or MAX_HEIGHT acts as that maximum; size or threshold writes take
// effect at once without restarting the frame.
module dark_pixel_centroid
    import dpc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write port
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Pixel request channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [PIX_W-1:0]       pixel_value,
    // Result request channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [COORD_W-1:0]     centroid_x,
    output logic [COORD_W-1:0]     centroid_y,
    output logic [COUNT_W-1:0]     dark_count,
    output logic                   no_dark_pixels
);

    // Counter widths and compare widths from the frame bounds
    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int XS0 = $clog2(MAX_WIDTH + 1);
    localparam int YS0 = $clog2(MAX_HEIGHT + 1);
    localparam int XS  = (XS0 > CFG_SIZE_W) ? XS0 : CFG_SIZE_W;
    localparam int YS  = (YS0 > CFG_SIZE_W) ? YS0 : CFG_SIZE_W;
    localparam logic [XS-1:0] MAX_W_C = XS'(MAX_WIDTH);
    localparam logic [YS-1:0] MAX_H_C = YS'(MAX_HEIGHT);

    dpc_state_t           state_reg, state_next;

    logic [PIX_W-1:0]      threshold_reg;
    logic [CFG_SIZE_W-1:0] width_reg;
    logic [CFG_SIZE_W-1:0] height_reg;

    logic [XW-1:0]         col_reg, col_next;
    logic [YW-1:0]         row_reg, row_next;
    logic [SUM_W-1:0]      col_sum_reg, col_sum_next;
    logic [SUM_W-1:0]      row_sum_reg, row_sum_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [COORD_W-1:0]    qx_reg;

    logic                  out_valid_reg;
    logic [COORD_W-1:0]    centroid_x_reg;
    logic [COORD_W-1:0]    centroid_y_reg;
    logic [COUNT_W-1:0]    dark_count_reg;
    logic                  no_dark_reg;

    logic [XS-1:0]         w_size;
    logic [XS-1:0]         w_eff;
    logic [YS-1:0]         h_size;
    logic [YS-1:0]         h_eff;
    logic [XS-1:0]         col_plus;
    logic [YS-1:0]         row_plus;
    logic                  col_last;
    logic                  row_last;
    logic                  frame_last;
    logic                  accept;
    logic                  is_dark;
    logic                  out_free;
    logic                  div_start;
    logic                  capture_x;
    logic                  load_out;
    logic [SUM_W-1:0]      div_dividend;
    logic [COUNT_W-1:0]    div_divisor;
    logic [SUM_W-1:0]      div_quotient;
    dpc_div_stat_t         div_stat;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DARK_THRESHOLD: threshold_reg <= cfg_data[PIX_W-1:0];
                REG_FRAME_WIDTH:    width_reg     <= cfg_data[CFG_SIZE_W-1:0];
                REG_FRAME_HEIGHT:   height_reg    <= cfg_data[CFG_SIZE_W-1:0];
                default:            threshold_reg <= threshold_reg;
            endcase
        end
    end

    // Clamp the frame size into one to the maximum
    always_comb
    begin
        w_size = XS'(width_reg);
        h_size = YS'(height_reg);
        if (w_size == '0)
            w_eff = XS'(1);
        else if (w_size > MAX_W_C)
            w_eff = MAX_W_C;
        else
            w_eff = w_size;
        if (h_size == '0)
            h_eff = YS'(1);
        else if (h_size > MAX_H_C)
            h_eff = MAX_H_C;
        else
            h_eff = h_size;
    end

    // Detect row and frame ends
    always_comb
    begin
        col_plus   = XS'(col_reg) + XS'(1);
        row_plus   = YS'(row_reg) + YS'(1);
        col_last   = !(col_plus < w_eff);
        row_last   = !(row_plus < h_eff);
        frame_last = col_last && row_last;
        accept     = in_valid && !in_stall;
        is_dark    = (pixel_value < threshold_reg);
        out_free   = !out_valid_reg || !out_stall;
    end

    // Advance position, accumulate dark pixels, clear once the result is loaded
    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        col_sum_next = col_sum_reg;
        row_sum_next = row_sum_reg;
        count_next   = count_reg;
        if (accept)
        begin
            if (is_dark)
            begin
                col_sum_next = col_sum_reg + SUM_W'(col_reg);
                row_sum_next = row_sum_reg + SUM_W'(row_reg);
                count_next   = count_reg + COUNT_W'(1);
            end
            if (!col_last)
            begin
                col_next = col_plus[XW-1:0];
            end
            else
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_plus[YW-1:0];
            end
        end
        if (load_out)
        begin
            col_sum_next = '0;
            row_sum_next = '0;
            count_next   = '0;
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_ACCUM:
            begin
                if (accept && frame_last)
                    state_next = (count_next == '0) ? ST_FLUSH : ST_DIV_X;
            end
            ST_DIV_X:
            begin
                if (div_stat.done)
                    state_next = ST_DIV_Y;
            end
            ST_DIV_Y:
            begin
                if (div_stat.done)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                if (out_free)
                    state_next = ST_ACCUM;
            end
            default: state_next = ST_ACCUM;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_stall     = 1'b1;
        div_start    = 1'b0;
        capture_x    = 1'b0;
        load_out     = 1'b0;
        div_dividend = row_sum_reg;
        div_divisor  = count_reg;
        case (state_reg)
            ST_ACCUM:
            begin
                in_stall     = 1'b0;
                div_dividend = col_sum_next;
                div_divisor  = count_next;
                div_start    = accept && frame_last && (count_next != '0);
            end
            ST_DIV_X:
            begin
                div_start = div_stat.done;
                capture_x = div_stat.done;
            end
            ST_DIV_Y:
            begin
                div_start = 1'b0;
            end
            ST_FLUSH:
            begin
                load_out = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Shared divider for both mean coordinates
    dpc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    // Control and accumulator registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            col_reg       <= '0;
            row_reg       <= '0;
            col_sum_reg   <= '0;
            row_sum_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            col_sum_reg <= col_sum_next;
            row_sum_reg <= row_sum_next;
            count_reg   <= count_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Hold the column mean and the result payload
    always_ff @(posedge clk)
    begin
        if (capture_x)
            qx_reg <= div_quotient[COORD_W-1:0];
        if (load_out)
        begin
            no_dark_reg    <= (count_reg == '0);
            dark_count_reg <= count_reg;
            centroid_x_reg <= (count_reg == '0) ? '0 : qx_reg;
            centroid_y_reg <= (count_reg == '0) ? '0 : div_quotient[COORD_W-1:0];
        end
    end

    assign out_valid      = out_valid_reg;
    assign centroid_x     = centroid_x_reg;
    assign centroid_y     = centroid_y_reg;
    assign dark_count     = dark_count_reg;
    assign no_dark_pixels = no_dark_reg;

    // The last pixel of a frame always leaves the accumulate state
    a_frame_end_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && frame_last) |=> (state_reg != ST_ACCUM))
        else $error("frame end did not stop input");

    // The divider is idle whenever pixels are taken
    a_div_idle_accum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACCUM) |-> !div_stat.busy)
        else $error("divider busy while accumulating");

    // An empty frame reports zero coordinates and count
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && no_dark_pixels) |->
        (centroid_x == '0 && centroid_y == '0 && dark_count == '0))
        else $error("empty frame result not zero");

    // A non-empty result carries a nonzero count
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !no_dark_pixels) |-> (dark_count != '0))
        else $error("dark result with zero count");

endmodule
